>>> sv/assert_macros.svh
// Assertion macros used by the epoch sync checker back end (esc_back).
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/esc_pkg.sv
// Package for the epoch sync checker: widths, codes, decoded item type.
// Used by every module of the block; depends on nothing.
package esc_pkg;

  localparam int WORD_W      = 64;
  localparam int CHIP_W      = 8;
  localparam int EPOCH_W     = 24;
  localparam int CNT_W       = 32;
  localparam int CHIP_SLOTS  = 128;
  localparam int CHIP_IDX_W  = $clog2(CHIP_SLOTS);
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [47:0]        END_MARK    = 48'hdeadbeeeeeef;
  localparam logic [3:0]         TYPE_EPOCH  = 4'h1;
  localparam logic [CHIP_W-1:0]  GLOBAL_CHIP = 8'hFF;
  localparam logic [CHIP_W-1:0]  LAST_CHIP   = 8'd120;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_END          = 3'd0,
    ST_OTHER        = 3'd1,
    ST_GLOBAL_OK    = 3'd2,
    ST_GLOBAL_JUMP  = 3'd3,
    ST_GLOBAL_OVF   = 3'd4,
    ST_CHIP_OK      = 3'd5,
    ST_CHIP_DRIFT   = 3'd6,
    ST_CHIP_IGNORED = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_OTHER,
    CLS_GLOBAL,
    CLS_CHIP,
    CLS_IGNORED
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [CHIP_W-1:0]  chip;
    logic [EPOCH_W-1:0] epoch;
  } item_t;

endpackage

>>> sv/esc_front.sv
// Front end of the epoch sync checker: accepts raw words and classifies them.
// Depends on esc_pkg; feeds esc_queue.
module esc_front import esc_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_message_word,
  input  logic              q_full,
  output logic              push,
  output item_t             push_item
);

  logic [3:0] kind;

  assign kind     = in_message_word[3:0];
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Decode fields and classify the word
  always_comb begin
    push_item.chip  = in_message_word[47:40];
    push_item.epoch = in_message_word[31:8];
    priority if (in_message_word[47:0] == END_MARK) begin
      push_item.cls = CLS_END;
    end else if (kind != TYPE_EPOCH) begin
      push_item.cls = CLS_OTHER;
    end else if (push_item.chip == GLOBAL_CHIP) begin
      push_item.cls = CLS_GLOBAL;
    end else if (push_item.chip <= LAST_CHIP) begin
      push_item.cls = CLS_CHIP;
    end else begin
      push_item.cls = CLS_IGNORED;
    end
  end

endmodule

>>> sv/esc_queue.sv
// Short request queue between the front end and the back end.
// Depends on esc_pkg for the item type and depth.
module esc_queue import esc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head_item
);

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

>>> sv/esc_back.sv
// Back end of the epoch sync checker: global epoch and counter update, chip lag
// table read-modify-write over two stages, output register. Depends on esc_pkg.
module esc_back import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [CHIP_W-1:0]  out_chip_id,
  output logic [EPOCH_W-1:0] out_epoch_value,
  output logic [EPOCH_W-1:0] out_previous_global,
  output logic [EPOCH_W-1:0] out_lag_now,
  output logic [EPOCH_W-1:0] out_lag_before,
  output logic [CNT_W-1:0]   out_epochs_since_error
);

  `include "assert_macros.svh"

  // Held state
  logic [EPOCH_W-1:0] glob_r, glob_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Chip lag table and its valid bits
  logic [EPOCH_W-1:0] lag_mem [CHIP_SLOTS];
  logic [CHIP_SLOTS-1:0] lag_vld_r;

  // Stage B registers
  logic               b_valid_r;
  status_t            b_status_r;
  logic [CHIP_W-1:0]  b_chip_r;
  logic [EPOCH_W-1:0] b_epoch_r, b_prev_r, b_lag_r, b_fwd_lag_r, rd_data_r;
  logic [CNT_W-1:0]   b_count_r;
  logic               b_is_chip_r, b_fwd_r, rd_vld_r;

  // Output registers
  logic               out_valid_r;
  status_t            out_status_r;
  logic [CHIP_W-1:0]  out_chip_r;
  logic [EPOCH_W-1:0] out_epoch_r, out_prev_r, out_lag_now_r, out_lag_before_r;
  logic [CNT_W-1:0]   out_count_r;

  // Stage A signals
  logic                  out_load, b_take, fwd;
  logic [CHIP_IDX_W-1:0] a_addr, b_addr;
  status_t               a_status, b_final_status;
  logic [EPOCH_W-1:0]    a_lag, a_lag_calc, b_lag_before;
  logic [CNT_W-1:0]      a_count, cnt_inc;

  // Assertion terms
  logic                  chk_jump, chk_ovf, chk_lag_set, chk_out_chip;

  assign out_load = b_valid_r && (!out_valid_r || out_ready);
  assign b_take   = !b_valid_r || out_load;
  assign q_pop    = q_valid && b_take;
  assign a_addr   = q_item.chip[CHIP_IDX_W-1:0];
  assign b_addr   = b_chip_r[CHIP_IDX_W-1:0];
  // Stage B writes the same entry that stage A reads at this edge
  assign fwd      = out_load && b_is_chip_r && (q_item.cls == CLS_CHIP) &&
                    (b_addr == a_addr);

  assign cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign a_lag_calc = (glob_r > q_item.epoch) ? glob_r - q_item.epoch
                                              : glob_r - q_item.epoch - 1'b1;

  // Classify against held global state
  always_comb begin
    glob_nxt = glob_r;
    cnt_nxt  = cnt_r;
    a_status = ST_OTHER;
    a_lag    = '0;
    a_count  = cnt_r;
    unique case (q_item.cls)
      CLS_END:     a_status = ST_END;
      CLS_OTHER:   a_status = ST_OTHER;
      CLS_GLOBAL: begin
        a_count  = cnt_inc;
        cnt_nxt  = cnt_inc;
        glob_nxt = q_item.epoch;
        if (glob_r == EPOCH_MAX) begin
          a_status = ST_GLOBAL_OVF;
        end else if (glob_r + 1'b1 != q_item.epoch) begin
          a_status = ST_GLOBAL_JUMP;
          cnt_nxt  = '0;
        end else begin
          a_status = ST_GLOBAL_OK;
        end
      end
      CLS_CHIP: begin
        a_status = ST_CHIP_OK;
        a_lag    = a_lag_calc;
      end
      CLS_IGNORED: a_status = ST_CHIP_IGNORED;
      default:     a_status = ST_OTHER;
    endcase
  end

  // Update global epoch and error-free counter in request order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r <= '0;
      cnt_r  <= '0;
    end else if (q_pop) begin
      glob_r <= glob_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Read and write the lag table
  always_ff @(posedge clk) begin
    if (q_pop) rd_data_r <= lag_mem[a_addr];
    if (out_load && b_is_chip_r) lag_mem[b_addr] <= b_lag_r;
  end

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_vld_r <= '0;
    end else if (out_load && b_is_chip_r) begin
      lag_vld_r[b_addr] <= 1'b1;
    end
  end

  // Stage B control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_take) begin
      b_valid_r <= q_pop;
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_status_r  <= a_status;
      b_chip_r    <= q_item.chip;
      b_epoch_r   <= q_item.epoch;
      b_prev_r    <= glob_r;
      b_lag_r     <= a_lag;
      b_count_r   <= a_count;
      b_is_chip_r <= (q_item.cls == CLS_CHIP);
      b_fwd_r     <= fwd;
      b_fwd_lag_r <= b_lag_r;
      rd_vld_r    <= lag_vld_r[a_addr];
    end
  end

  // Resolve stored lag and drift
  always_comb begin
    b_lag_before   = '0;
    b_final_status = b_status_r;
    if (b_is_chip_r) begin
      if (b_fwd_r) begin
        b_lag_before = b_fwd_lag_r;
      end else if (rd_vld_r) begin
        b_lag_before = rd_data_r;
      end
      b_final_status = (b_lag_r != b_lag_before) ? ST_CHIP_DRIFT : ST_CHIP_OK;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= b_valid_r;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r     <= b_final_status;
      out_chip_r       <= b_chip_r;
      out_epoch_r      <= b_epoch_r;
      out_prev_r       <= b_prev_r;
      out_lag_now_r    <= b_lag_r;
      out_lag_before_r <= b_lag_before;
      out_count_r      <= b_count_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_chip_id            = out_chip_r;
  assign out_epoch_value        = out_epoch_r;
  assign out_previous_global    = out_prev_r;
  assign out_lag_now            = out_lag_now_r;
  assign out_lag_before         = out_lag_before_r;
  assign out_epochs_since_error = out_count_r;

  assign chk_jump     = q_pop && (a_status == ST_GLOBAL_JUMP);
  assign chk_ovf      = q_pop && (a_status == ST_GLOBAL_OVF);
  assign chk_lag_set  = out_valid_r && (out_lag_before_r != '0);
  assign chk_out_chip = (out_status_r == ST_CHIP_OK) || (out_status_r == ST_CHIP_DRIFT);

  `ASSERT_NEXT(a_jump_clears, chk_jump, cnt_r == '0, "counter not cleared after jump")
  `ASSERT_IMP(a_ovf_held_max, chk_ovf, glob_r == EPOCH_MAX, "overflow without all-ones epoch")
  `ASSERT_IMP(a_fwd_chip, b_valid_r && b_fwd_r, b_is_chip_r, "forwarded lag on non-chip request")
  `ASSERT_IMP(a_lag_chip_only, chk_lag_set, chk_out_chip, "stored lag reported for non-chip word")

endmodule

>>> sv/epoch_sync_checker_top.sv
// Epoch sync checker: checks global and per-chip epoch consistency of a
// 64-bit readout word stream, one result per word.
// Channels: in_valid/in_ready carry in_message_word; out_valid/out_ready carry
// the result fields out_status .. out_epochs_since_error. A word is taken on
// an edge where valid and ready are both high.
// Throughput: one word per cycle while out_ready stays high. The chip lag table
// is read in one stage and written in the next, with forwarding between
// neighbors, so its single read and write port set that rate.
// Path: an accepted word is written into the queue, then held in the lag stage,
// then loaded into the output register that presents its result.
// Reset (rst_n low, synchronous): global epoch and error-free count go to
// zero, and all chip lag table valid bits clear at once, so no clearing pass
// is needed; the queue and both stages empty.
// Stall: when out_ready is low the result holds in the output register, the
// lag stage holds one more, and the four-entry queue absorbs further words;
// in_ready drops only when that queue is full.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
module epoch_sync_checker_top import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  in_message_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [CHIP_W-1:0]  out_chip_id,
  output logic [EPOCH_W-1:0] out_epoch_value,
  output logic [EPOCH_W-1:0] out_previous_global,
  output logic [EPOCH_W-1:0] out_lag_now,
  output logic [EPOCH_W-1:0] out_lag_before,
  output logic [CNT_W-1:0]   out_epochs_since_error
);

  logic  q_full, q_not_empty, push, pop;
  item_t push_item, head_item;

  esc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message_word (in_message_word),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  esc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  esc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_not_empty),
    .q_item                 (head_item),
    .q_pop                  (pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_chip_id            (out_chip_id),
    .out_epoch_value        (out_epoch_value),
    .out_previous_global    (out_previous_global),
    .out_lag_now            (out_lag_now),
    .out_lag_before         (out_lag_before),
    .out_epochs_since_error (out_epochs_since_error)
  );

endmodule

>>> tb/tb_epoch_sync_checker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for epoch_sync_checker_top: directed table, then random word stream.
// Depends on esc_pkg and the epoch_sync_checker_top RTL; predicts untyped results in-line.
module tb_epoch_sync_checker_top;
  import esc_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [CHIP_W-1:0]  chip;
    logic [EPOCH_W-1:0] epoch;
    logic [EPOCH_W-1:0] prev_global;
    logic [EPOCH_W-1:0] lag_now;
    logic [EPOCH_W-1:0] lag_before;
    logic [CNT_W-1:0]   since_error;
  } epoch_result_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              typed;
    epoch_result_t     res;
  } stim_row_t;

  localparam int RANDOM_WORDS = 1100;
  localparam int HOLD_CYCLES  = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [WORD_W-1:0]  in_message_word = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [CHIP_W-1:0]  out_chip_id;
  logic [EPOCH_W-1:0] out_epoch_value;
  logic [EPOCH_W-1:0] out_previous_global;
  logic [EPOCH_W-1:0] out_lag_now;
  logic [EPOCH_W-1:0] out_lag_before;
  logic [CNT_W-1:0]   out_epochs_since_error;

  // Mirror of the checker state
  logic [EPOCH_W-1:0] held_global;
  logic [CNT_W-1:0]   held_since_error;
  logic [EPOCH_W-1:0] chip_lag_mirror [CHIP_SLOTS];

  epoch_result_t pending_results [$];
  stim_row_t     directed_rows [$];

  int  mismatch_cnt = 0;
  int  results_checked = 0;
  int  requests_sent = 0;
  int  in_stall_cycles = 0;
  int  status_seen [8];
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  hold_req = 1'b0;

  always #1 clk = ~clk;

  epoch_sync_checker_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_message_word        (in_message_word),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_chip_id            (out_chip_id),
    .out_epoch_value        (out_epoch_value),
    .out_previous_global    (out_previous_global),
    .out_lag_now            (out_lag_now),
    .out_lag_before         (out_lag_before),
    .out_epochs_since_error (out_epochs_since_error)
  );

  // Decode one word, update the mirrored state and return its result
  function automatic epoch_result_t predict_epoch_check(input logic [WORD_W-1:0] w);
    epoch_result_t r;
    logic [EPOCH_W-1:0] ep;
    ep            = w[31:8];
    r.chip        = w[47:40];
    r.epoch       = ep;
    r.prev_global = held_global;
    r.lag_now     = '0;
    r.lag_before  = '0;
    r.since_error = held_since_error;
    if (w[47:0] == END_MARK) begin
      r.status = ST_END;
    end else if (w[3:0] != TYPE_EPOCH) begin
      r.status = ST_OTHER;
    end else if (r.chip == GLOBAL_CHIP) begin
      // count first, report, then clear on a jump
      if (held_since_error != '1) held_since_error = held_since_error + 1'b1;
      r.since_error = held_since_error;
      if (held_global == EPOCH_MAX) begin
        r.status = ST_GLOBAL_OVF;
      end else if (held_global + 1'b1 != ep) begin
        r.status = ST_GLOBAL_JUMP;
        held_since_error = '0;
      end else begin
        r.status = ST_GLOBAL_OK;
      end
      held_global = ep;
    end else if (r.chip <= LAST_CHIP) begin
      // lag wraps through all ones when the chip is not behind
      if (held_global > ep) r.lag_now = held_global - ep;
      else r.lag_now = EPOCH_MAX + held_global - ep;
      r.lag_before = chip_lag_mirror[r.chip];
      r.status = (r.lag_now != r.lag_before) ? ST_CHIP_DRIFT : ST_CHIP_OK;
      chip_lag_mirror[r.chip] = r.lag_now;
    end else begin
      r.status = ST_CHIP_IGNORED;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] epoch_word(input logic [CHIP_W-1:0] chip,
                                                   input logic [EPOCH_W-1:0] ep);
    return {16'h0000, chip, 8'h00, ep, 4'h0, TYPE_EPOCH};
  endfunction

  // Random word, mostly well-formed epoch traffic that follows the held global epoch
  function automatic logic [WORD_W-1:0] next_random_word();
    int                 pick;
    logic [WORD_W-1:0]  w;
    logic [CHIP_W-1:0]  chip;
    logic [EPOCH_W-1:0] ep;
    logic [3:0]         kind;
    w    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 19))
        0, 1:    ep = EPOCH_W'($urandom);
        2:       ep = EPOCH_MAX - 1'b1;
        default: ep = held_global + 1'b1;
      endcase
      w[47:40] = GLOBAL_CHIP;
      w[31:8]  = ep;
      w[3:0]   = TYPE_EPOCH;
    end else if (pick < 65) begin
      // a few busy chips so lags get compared often
      if ($urandom_range(0, 3) != 0) chip = CHIP_W'($urandom_range(0, 7));
      else if ($urandom_range(0, 1) != 0) chip = LAST_CHIP;
      else chip = CHIP_W'($urandom_range(0, LAST_CHIP));
      case ($urandom_range(0, 7))
        0, 1:    ep = held_global - EPOCH_W'($urandom_range(0, 3));
        2:       ep = EPOCH_W'($urandom);
        default: ep = held_global - chip_lag_mirror[chip];
      endcase
      w[47:40] = chip;
      w[31:8]  = ep;
      w[3:0]   = TYPE_EPOCH;
    end else if (pick < 75) begin
      w[47:40] = CHIP_W'($urandom_range(LAST_CHIP + 1, GLOBAL_CHIP - 1));
      w[3:0]   = TYPE_EPOCH;
    end else if (pick < 83) begin
      w[47:0] = END_MARK;
    end else if (pick < 93) begin
      kind = 4'($urandom_range(0, 14));
      if (kind >= TYPE_EPOCH) kind = kind + 1'b1;
      w[3:0] = kind;
    end
    return w;
  endfunction

  task automatic add_typed_row(input logic [WORD_W-1:0] w, input status_t st,
                               input logic [CHIP_W-1:0] chip, input logic [EPOCH_W-1:0] ep,
                               input logic [EPOCH_W-1:0] prev, input logic [EPOCH_W-1:0] lnow,
                               input logic [EPOCH_W-1:0] lbef, input logic [CNT_W-1:0] cnt);
    stim_row_t row;
    row.word  = w;
    row.typed = 1'b1;
    row.res   = '{st, chip, ep, prev, lnow, lbef, cnt};
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_checked_row(input logic [WORD_W-1:0] w);
    stim_row_t row;
    row       = '0;
    row.word  = w;
    directed_rows = {directed_rows, row};
  endtask

  // Offer one request after a random gap, hold it until taken, then queue its result
  task automatic send_request(input logic [WORD_W-1:0] w, input logic typed,
                              input epoch_result_t typed_res);
    int            gap;
    epoch_result_t r;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_message_word <= w;
    do @(posedge clk); while (!in_ready);
    r = predict_epoch_check(w);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
    requests_sent++;
  endtask

  task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    epoch_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: out_status %0d, out_chip_id 0x%0h", out_status, out_chip_id);
      mismatch_cnt++;
    end else begin
      want = pending_results.pop_front();
      compare_field("out_status", want.status, out_status);
      compare_field("out_chip_id", want.chip, out_chip_id);
      compare_field("out_epoch_value", want.epoch, out_epoch_value);
      compare_field("out_previous_global", want.prev_global, out_previous_global);
      compare_field("out_lag_now", want.lag_now, out_lag_now);
      compare_field("out_lag_before", want.lag_before, out_lag_before);
      compare_field("out_epochs_since_error", want.since_error, out_epochs_since_error);
      status_seen[want.status]++;
      results_checked++;
    end
  endtask

  // Check each result taken and count input backpressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (rst_n && in_valid && !in_ready) in_stall_cycles++;
  end

  // Result side: random stalls per result, one long hold-off on request
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int      i;
    int      k;
    string   mix;
    status_t st;

    held_global      = '0;
    held_since_error = '0;
    foreach (chip_lag_mirror[k]) chip_lag_mirror[k] = '0;

    // Rows with results readable by eye right after reset
    add_typed_row(64'h0000_dead_beee_eeef, ST_END, 8'hde, 24'hbeeeee, '0, '0, '0, '0);
    add_typed_row(64'h0, ST_OTHER, '0, '0, '0, '0, '0, '0);
    add_typed_row('1, ST_OTHER, 8'hff, 24'hffffff, '0, '0, '0, '0);
    add_typed_row(epoch_word(GLOBAL_CHIP, 24'd1), ST_GLOBAL_OK, 8'hff, 24'd1, '0, '0, '0, 32'd1);
    add_typed_row(epoch_word(8'd0, 24'd1), ST_CHIP_DRIFT, 8'd0, 24'd1, 24'd1, 24'hffffff, '0,
                  32'd1);
    add_typed_row(epoch_word(GLOBAL_CHIP, 24'd1), ST_GLOBAL_JUMP, 8'hff, 24'd1, 24'd1, '0, '0,
                  32'd2);
    add_typed_row(epoch_word(8'd0, 24'd0), ST_CHIP_DRIFT, 8'd0, 24'd0, 24'd1, 24'd1,
                  24'hffffff, '0);
    // Rest of the corner walk goes through the predictor
    add_checked_row(epoch_word(8'd0, 24'd0));
    add_checked_row(epoch_word(LAST_CHIP, 24'd5));
    add_checked_row(epoch_word(8'd121, 24'd9));
    add_checked_row(64'hffff_fe00_0000_0101);
    add_checked_row(64'hffff_dead_beee_eeef);
    add_checked_row(64'h0000_dead_beee_eee1);
    add_checked_row(64'h0000_03ff_0000_07f1);
    add_checked_row(epoch_word(GLOBAL_CHIP, 24'd2));
    add_checked_row(epoch_word(GLOBAL_CHIP, 24'hfffffe));
    add_checked_row(epoch_word(GLOBAL_CHIP, 24'hffffff));
    add_checked_row(epoch_word(8'd5, 24'hffffff));
    add_checked_row(epoch_word(GLOBAL_CHIP, 24'd0));
    add_checked_row(epoch_word(8'd7, 24'hffffff));
    add_checked_row(epoch_word(LAST_CHIP, 24'd0));
    add_checked_row(epoch_word(GLOBAL_CHIP, 24'd1));
    add_checked_row(64'hffff_ffff_ffff_fff2);
    add_checked_row(epoch_word(8'd127, 24'h123456));

    // Hold reset, then release on an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].res);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      // Reshuffle idling every block so both busy and quiet stretches occur
      if (i % 64 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      // Back-to-back requests while the result side holds off
      if (i == 300) hold_req = 1'b1;
      if (i >= 300 && i < 340) tx_idle = 1'b0;
      // Drop valid and let every result drain before going on
      if (i == 700) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      send_request(next_random_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);

    mix = "";
    for (k = 0; k < 8; k++) begin
      st  = status_t'(k);
      mix = {mix, $sformatf(" %s=%0d", st.name(), status_seen[k])};
    end
    $display("covered %0d requests (%0d table rows), %0d results checked, %0d input stall cycles",
             requests_sent, directed_rows.size(), results_checked, in_stall_cycles);
    $display("result mix:%s", mix);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/esc_pkg.sv
sv/esc_front.sv
sv/esc_queue.sv
sv/esc_back.sv
sv/epoch_sync_checker_top.sv
tb/tb_epoch_sync_checker_top.sv
